// File: rtl/core/wmrh_pkg.sv
// Package: constants, microcode types and the microcode ROM of the word multiply-rotate hash.
`default_nettype none

package wmrh_pkg;

    localparam logic [63:0] HASH_SEED  = 64'h84222325CBF29CE4;
    localparam logic [63:0] HASH_MUL   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] FOLD_ADD   = 64'h0000000052DCE729;
    localparam logic [63:0] FMIX_MUL_A = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] FMIX_MUL_B = 64'hC4CEB9FE1A85EC53;

    localparam int unsigned WORD_BYTES = 8;
    localparam int unsigned STEP_W     = 5;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses.
    localparam t_step ST_IDLE    = 5'd0;
    localparam t_step ST_FOLD    = 5'd8;
    localparam t_step ST_FINAL   = 5'd13;
    localparam t_step ST_TAIL    = 5'd22;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,     // wait for an input transfer
        OP_MUL1,     // product = acc.lo * c.lo
        OP_MUL2,     // product.hi += (acc.hi * c.lo).lo
        OP_MUL3,     // acc = {product.hi + (acc.lo * c.hi).lo, product.lo}
        OP_ROT31,    // acc = rotl(acc, 31)
        OP_FOLDPREP, // acc = rotl(hash ^ acc, 27)
        OP_ADDC,     // hash = acc + fold constant
        OP_XORH,     // hash = hash ^ acc
        OP_FIN0,     // acc = h ^ (h >> 33), h = hash ^ length
        OP_XS33,     // acc = acc ^ (acc >> 33)
        OP_OUT       // result register = acc ^ (acc >> 33), state back to seed
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_EMPTY_LAST,
        C_TAIL,
        C_NOT_LAST
    } t_cond;

    typedef enum logic [1:0] {
        CS_MUL,
        CS_FMIX_A,
        CS_FMIX_B
    } t_csel;

    typedef struct packed {
        t_op   op;
        t_csel csel;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic empty_last;
        logic tail;
        logic last;
        logic out_busy;
    } t_status;

    function automatic t_ctrl ucode_rom(input t_step step);
        t_ctrl w;
        w = '{op: OP_NOP, csel: CS_MUL, cond: C_ALWAYS, target: ST_IDLE};
        case (step)
            5'd0:  w = '{OP_IDLE,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd1:  w = '{OP_MUL1,     CS_MUL,    C_EMPTY_LAST, ST_FINAL};
            5'd2:  w = '{OP_MUL2,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd3:  w = '{OP_MUL3,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd4:  w = '{OP_ROT31,    CS_MUL,    C_NEXT,       ST_IDLE};
            5'd5:  w = '{OP_MUL1,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd6:  w = '{OP_MUL2,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd7:  w = '{OP_MUL3,     CS_MUL,    C_TAIL,       ST_TAIL};
            5'd8:  w = '{OP_FOLDPREP, CS_MUL,    C_NEXT,       ST_IDLE};
            5'd9:  w = '{OP_MUL1,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd10: w = '{OP_MUL2,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd11: w = '{OP_MUL3,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd12: w = '{OP_ADDC,     CS_MUL,    C_NOT_LAST,   ST_IDLE};
            5'd13: w = '{OP_FIN0,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd14: w = '{OP_MUL1,     CS_FMIX_A, C_NEXT,       ST_IDLE};
            5'd15: w = '{OP_MUL2,     CS_FMIX_A, C_NEXT,       ST_IDLE};
            5'd16: w = '{OP_MUL3,     CS_FMIX_A, C_NEXT,       ST_IDLE};
            5'd17: w = '{OP_XS33,     CS_MUL,    C_NEXT,       ST_IDLE};
            5'd18: w = '{OP_MUL1,     CS_FMIX_B, C_NEXT,       ST_IDLE};
            5'd19: w = '{OP_MUL2,     CS_FMIX_B, C_NEXT,       ST_IDLE};
            5'd20: w = '{OP_MUL3,     CS_FMIX_B, C_NEXT,       ST_IDLE};
            5'd21: w = '{OP_OUT,      CS_MUL,    C_ALWAYS,     ST_IDLE};
            5'd22: w = '{OP_XORH,     CS_MUL,    C_ALWAYS,     ST_FINAL};
            default: w = '{OP_NOP,    CS_MUL,    C_ALWAYS,     ST_IDLE};
        endcase
        return w;
    endfunction

    // Keeps the first count bytes of a word; count is already saturated to 8.
    function automatic logic [63:0] byte_mask(input logic [3:0] count);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < WORD_BYTES; i++) begin
            m[8*i +: 8] = (4'(i) < count) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/wmrh_if.sv
// Interfaces: valid/ready channels for message words and hash results.
`default_nettype none

interface wmrh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;

    modport source (output valid, output data_word, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last,
                    output ready);
endinterface

interface wmrh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        framing_error;

    modport source (output valid, output hash_value, output framing_error, input ready);
    modport sink   (input valid, input hash_value, input framing_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wmrh_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`default_nettype none

module wmrh_sequencer
    import wmrh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output t_ctrl        o_ctrl,
    output logic         o_go,
    output logic         o_in_ready
);

    t_step r_step;
    t_step n_step;
    t_ctrl ctrl;
    logic  taken;

    assign ctrl       = ucode_rom(r_step);
    assign o_ctrl     = ctrl;
    assign o_in_ready = (ctrl.op == OP_IDLE);

    always_comb begin
        case (ctrl.op)
            OP_IDLE: o_go = i_in_valid;
            OP_OUT:  o_go = !i_status.out_busy;
            default: o_go = 1'b1;
        endcase

        case (ctrl.cond)
            C_ALWAYS:     taken = 1'b1;
            C_EMPTY_LAST: taken = i_status.empty_last;
            C_TAIL:       taken = i_status.tail;
            C_NOT_LAST:   taken = !i_status.last;
            default:      taken = 1'b0;
        endcase

        if (!o_go) begin
            n_step = r_step;
        end else if (taken) begin
            n_step = ctrl.target;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wmrh_datapath.sv
// Datapath: hash state, working registers, shared 32x32 multiplier and result register.
`default_nettype none

module wmrh_datapath
    import wmrh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctrl       i_ctrl,
    input  wire logic        i_go,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last,
    input  wire logic        i_out_ready,
    output t_status          o_status,
    output logic             o_out_valid,
    output logic [63:0]      o_hash_value,
    output logic             o_framing_error
);

    logic [63:0] r_hash;
    logic [63:0] r_len;
    logic        r_err;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [3:0]  r_cnt;
    logic        r_last;
    logic        r_out_valid;
    logic [63:0] r_out_hash;
    logic        r_out_err;

    logic [3:0]  sat_cnt;
    logic [63:0] cval;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] fin_h;

    assign sat_cnt = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;

    always_comb begin
        case (i_ctrl.csel)
            CS_FMIX_A: cval = FMIX_MUL_A;
            CS_FMIX_B: cval = FMIX_MUL_B;
            default:   cval = HASH_MUL;
        endcase
        mul_a = (i_ctrl.op == OP_MUL2) ? r_acc[63:32] : r_acc[31:0];
        mul_b = (i_ctrl.op == OP_MUL3) ? cval[63:32]  : cval[31:0];
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign fin_h = r_hash ^ r_len;

    assign o_status.empty_last = r_last && (r_cnt == 4'd0);
    assign o_status.tail       = r_last && (r_cnt != 4'd0) && (r_cnt != 4'd8);
    assign o_status.last       = r_last;
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_hash_value    = r_out_hash;
    assign o_framing_error = r_out_err;

    // Architectural state and the result handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= HASH_SEED;
            r_len       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_go) begin
                case (i_ctrl.op)
                    OP_IDLE: begin
                        r_len <= r_len + {60'd0, sat_cnt};
                        if (!i_last && (sat_cnt != 4'd8)) begin
                            r_err <= 1'b1;
                        end
                    end
                    OP_ADDC: r_hash <= r_acc + FOLD_ADD;
                    OP_XORH: r_hash <= r_hash ^ r_acc;
                    OP_OUT: begin
                        r_out_valid <= 1'b1;
                        r_hash      <= HASH_SEED;
                        r_len       <= '0;
                        r_err       <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            case (i_ctrl.op)
                OP_IDLE: begin
                    r_acc  <= i_data_word & byte_mask(sat_cnt);
                    r_cnt  <= sat_cnt;
                    r_last <= i_last;
                end
                OP_MUL1:     r_prod <= mul_p;
                OP_MUL2:     r_prod[63:32] <= r_prod[63:32] + mul_p[31:0];
                OP_MUL3:     r_acc <= {r_prod[63:32] + mul_p[31:0], r_prod[31:0]};
                OP_ROT31:    r_acc <= {r_acc[32:0], r_acc[63:33]};
                OP_FOLDPREP: r_acc <= {r_hash[36:0] ^ r_acc[36:0], r_hash[63:37] ^ r_acc[63:37]};
                OP_FIN0:     r_acc <= fin_h ^ {33'd0, fin_h[63:33]};
                OP_XS33:     r_acc <= r_acc ^ {33'd0, r_acc[63:33]};
                OP_OUT: begin
                    r_out_hash <= r_acc ^ {33'd0, r_acc[63:33]};
                    r_out_err  <= r_err;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/word_multiply_rotate_hash64.sv
// Top level: 64-bit word-stream multiply-rotate hash with an fmix64-style finalizer.
// A new word is taken only when the sequencer is back at its idle step. Every 64-bit
// multiply is three passes through the single 32x32 multiplier, and absorbing a full
// word needs three of them.
// Reset (synchronous, active low) returns the step counter to idle, clears the result valid
// flag and restores the running hash seed, the byte length and the error flag.
`default_nettype none

module word_multiply_rotate_hash64
    import wmrh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wmrh_in_if.sink      i_in,
    wmrh_out_if.source   o_out
);

    // The sequencer walks a fixed microprogram. Step 0 waits for an input transfer and
    // latches the masked word; the following steps mix it (multiply, rotate by 31, multiply),
    // then fold it into the running hash (xor, rotate by 27, multiply, add) or, for a short
    // last word, only xor it in. Last words then run the finalizer; empty ones skip to it.
    t_ctrl   ctrl;
    t_status status;
    logic    go;
    logic    in_ready;

    wmrh_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_go       (go),
        .o_in_ready (in_ready)
    );

    // The result register sits behind the output step, so a pending result does not
    // stop the next message from being transferred in and absorbed; only the output
    // step itself waits while an earlier result is still unclaimed.
    wmrh_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_go            (go),
        .i_data_word     (i_in.data_word),
        .i_byte_count    (i_in.byte_count),
        .i_last          (i_in.last),
        .i_out_ready     (o_out.ready),
        .o_status        (status),
        .o_out_valid     (o_out.valid),
        .o_hash_value    (o_out.hash_value),
        .o_framing_error (o_out.framing_error)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
